/* rtl/core/idsa_pkg.sv */
`default_nettype none

package idsa_pkg;

   // Table geometry.
   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);

   // Fixed field widths of the item ports.
   localparam int ID_W       = 32;
   localparam int INDEX_W    = 4;
   localparam int RELEASED_W = 5;
   localparam int RELEASED_MAX = (1 << RELEASED_W) - 1;

   // Operation codes carried by an input item.
   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_SWEEP   = 1'b1
   } op_type;

   // Command presented to the slot table in the work stage.
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [ID_W-1:0]   owner_id;
   } table_cmd_type;

   // Outcome of one command against the slot table.
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               full;
      logic               fresh;
      logic [COUNT_W-1:0] released;
   } table_rsp_type;

endpackage

`default_nettype wire

/* rtl/core/id_to_slot_allocator.sv */
`default_nettype none

// Slot allocator that binds 32-bit owner IDs to one of SLOT_COUNT table slots
// for the length of a frame. An acquire item returns the slot already held by
// its ID or claims the lowest free one; a sweep item frees every slot that was
// not acquired since the previous sweep and reports how many it freed. The
// block takes one item in every cycle (busy stays low) and strobes its result
// on rsp_valid once the item has passed the input register, the parallel ID
// compare and priority encoders of the slot table, and the result register.
// Results come in item order and cannot be stalled, so the receiver must
// capture each one in the cycle its strobe is high.
module id_to_slot_allocator (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_op,
   input  wire  [idsa_pkg::ID_W-1:0]         req_owner_id,
   output logic                              rsp_valid,
   output logic [idsa_pkg::INDEX_W-1:0]      rsp_slot_index,
   output logic                              rsp_full_res,
   output logic                              rsp_fresh,
   output logic [idsa_pkg::RELEASED_W-1:0]   rsp_released_count
);
   import idsa_pkg::*;

   logic              req_vld_ff;
   op_type            req_op_ff;
   logic [ID_W-1:0]   req_id_ff;
   table_cmd_type     cmd;
   table_rsp_type     tbl_rsp;
   logic [31:0]       slot_wide;
   logic [31:0]       released_wide;
   logic [RELEASED_W-1:0] released_in;

   logic                  rsp_valid_ff;
   logic [INDEX_W-1:0]    rsp_slot_ff;
   logic                  rsp_full_ff;
   logic                  rsp_fresh_ff;
   logic [RELEASED_W-1:0] rsp_released_ff;

   // The block never refuses an item.
   assign busy = 1'b0;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_op_ff <= op_type'(req_op);
         req_id_ff <= req_owner_id;
      end
   end

   assign cmd.valid    = req_vld_ff;
   assign cmd.op       = req_op_ff;
   assign cmd.owner_id = req_id_ff;

   idsa_slot_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (tbl_rsp)
   );

   // Fit the slot number and freed count to the port widths.
   always_comb begin
      slot_wide     = 32'(tbl_rsp.slot);
      released_wide = 32'(tbl_rsp.released);
      if (released_wide > 32'(RELEASED_MAX)) begin
         released_in = RELEASED_W'(RELEASED_MAX);
      end else begin
         released_in = released_wide[RELEASED_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         rsp_slot_ff     <= slot_wide[INDEX_W-1:0];
         rsp_full_ff     <= tbl_rsp.full;
         rsp_fresh_ff    <= tbl_rsp.fresh;
         rsp_released_ff <= released_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_full_res       = rsp_full_ff;
   assign rsp_fresh          = rsp_fresh_ff;
   assign rsp_released_count = rsp_released_ff;

endmodule

`default_nettype wire

/* rtl/core/idsa_slot_table.sv */
`default_nettype none

module idsa_slot_table (
   input  wire                    clock,
   input  wire                    reset,
   input  idsa_pkg::table_cmd_type cmd,
   output idsa_pkg::table_rsp_type rsp
);
   import idsa_pkg::*;

   logic [SLOT_COUNT-1:0] used_ff;
   logic [SLOT_COUNT-1:0] used_in;
   logic [SLOT_COUNT-1:0] seen_ff;
   logic [SLOT_COUNT-1:0] seen_in;
   logic [ID_W-1:0]       owner_ff [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] match;
   logic                  hit;
   logic [SLOT_W-1:0]     hit_idx;
   logic                  has_free;
   logic [SLOT_W-1:0]     free_idx;
   logic                  owner_wr;
   logic [SLOT_COUNT-1:0] stale;
   logic [COUNT_W-1:0]    stale_count;

   // Compare the ID against every used slot at once.
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match[i] = used_ff[i] && (owner_ff[i] == cmd.owner_id);
      end
   end

   // Lowest matching slot and lowest free slot.
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      has_free = 1'b0;
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (!used_ff[i]) begin
            has_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // Slots that a sweep would free, and how many there are.
   always_comb begin
      stale       = used_ff & ~seen_ff;
      stale_count = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         stale_count = stale_count + COUNT_W'(stale[i]);
      end
   end

   // Next table state and the outcome of the item.
   always_comb begin
      used_in      = used_ff;
      seen_in      = seen_ff;
      owner_wr     = 1'b0;
      rsp.slot     = '0;
      rsp.full     = 1'b0;
      rsp.fresh    = 1'b0;
      rsp.released = '0;
      if (cmd.valid) begin
         unique case (cmd.op)
            OP_SWEEP: begin
               used_in      = used_ff & seen_ff;
               seen_in      = '0;
               rsp.released = stale_count;
            end
            OP_ACQUIRE: begin
               priority if (hit) begin
                  seen_in[hit_idx] = 1'b1;
                  rsp.slot         = hit_idx;
               end else if (has_free) begin
                  used_in[free_idx] = 1'b1;
                  seen_in[free_idx] = 1'b1;
                  owner_wr          = 1'b1;
                  rsp.slot          = free_idx;
                  rsp.fresh         = 1'b1;
               end else begin
                  rsp.full = 1'b1;
               end
            end
            default: begin
               used_in = used_ff;
            end
         endcase
      end
   end

   // Used and seen bits clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         seen_ff <= '0;
      end else begin
         used_ff <= used_in;
         seen_ff <= seen_in;
      end
   end

   // Owner IDs are only read behind a set used bit, so they need no reset.
   always_ff @(posedge clock) begin
      if (owner_wr) begin
         owner_ff[free_idx] <= cmd.owner_id;
      end
   end

endmodule

`default_nettype wire
